FILE: sv/compressed_texel_block_decoder_macros.svh
// Assertion macros shared by the texel block decoder modules.
`ifndef COMPRESSED_TEXEL_BLOCK_DECODER_MACROS_SVH
`define COMPRESSED_TEXEL_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define CTBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define CTBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ctbd_pkg.sv
// Types, codes and helpers for the compressed texel block decoder.
package ctbd_pkg;

  localparam int MAX_DIM = 1024;
  localparam int MIN_DIM = 4;
  localparam int DIM_W   = 11;
  localparam int BLK_W   = 8;
  localparam int BCNT_W  = 9;
  localparam int IDX_W   = 20;

  localparam logic [1:0] FMT_RGB6A5 = 2'd0;
  localparam logic [1:0] FMT_RGBA8  = 2'd1;
  localparam logic [1:0] FMT_BGRA8  = 2'd2;

  localparam logic [1:0] MODE_TRANSP = 2'd0;
  localparam logic [1:0] MODE_AVG    = 2'd1;
  localparam logic [1:0] MODE_RAW    = 2'd2;
  localparam logic [1:0] MODE_BLEND  = 2'd3;

  localparam logic [1:0] CFG_OUT_FORMAT = 2'd0;
  localparam logic [1:0] CFG_TEX_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_TEX_HEIGHT = 2'd2;

  localparam logic [2:0] KIND_RAW   = 3'd0;
  localparam logic [2:0] KIND_AVG   = 3'd1;
  localparam logic [2:0] KIND_MIX53 = 3'd2;
  localparam logic [2:0] KIND_MIX35 = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  typedef logic [31:0] texel_t;
  typedef texel_t [3:0] palette_t;

  typedef struct packed {
    logic [31:0] index_word;
    logic [1:0]  pal_mode;
    logic [14:0] pal_color0;
    logic [14:0] pal_color1;
    logic [14:0] pal_color2;
    logic [14:0] pal_color3;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      texel_value;
    logic [IDX_W-1:0] texel_index;
    logic             block_done;
    logic             texture_done;
  } out_item_t;

  typedef struct packed {
    logic active;
    logic block_end;
  } emit_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

FILE: sv/ctbd_lane.sv
// One palette lane: builds one palette entry and converts it to the output format.
module ctbd_lane (
  input  logic [14:0]       c0_i,
  input  logic [14:0]       c1_i,
  input  logic [14:0]       raw_i,
  input  logic [2:0]        kind_i,
  input  logic [1:0]        fmt_i,
  output ctbd_pkg::texel_t  texel_o
);
  import ctbd_pkg::*;

  function automatic logic [4:0] mix(input logic [4:0] a, input logic [4:0] b,
                                     input logic [4:0] r, input logic [2:0] kind);
    logic [5:0] sum6;
    logic [7:0] m8;
    logic [4:0] res;
    sum6 = {1'b0, a} + {1'b0, b};
    m8   = 8'd0;
    res  = r;
    case (kind)
      KIND_AVG: begin
        res = sum6[5:1];
      end
      KIND_MIX53: begin
        m8  = ({3'b0, a} << 2) + {3'b0, a} + ({3'b0, b} << 1) + {3'b0, b};
        res = m8[7:3];
      end
      KIND_MIX35: begin
        m8  = ({3'b0, b} << 2) + {3'b0, b} + ({3'b0, a} << 1) + {3'b0, a};
        res = m8[7:3];
      end
      default: begin
        res = r;
      end
    endcase
    return res;
  endfunction

  function automatic logic [5:0] ext6(input logic [4:0] c);
    return (c == 5'd0) ? 6'd0 : {c, 1'b1};
  endfunction

  logic [4:0] red;
  logic [4:0] grn;
  logic [4:0] blu;

  assign red = mix(c0_i[4:0],   c1_i[4:0],   raw_i[4:0],   kind_i);
  assign grn = mix(c0_i[9:5],   c1_i[9:5],   raw_i[9:5],   kind_i);
  assign blu = mix(c0_i[14:10], c1_i[14:10], raw_i[14:10], kind_i);

  always_comb begin
    if (kind_i == KIND_CLEAR) begin
      texel_o = 32'd0;
    end else begin
      case (fmt_i)
        FMT_RGBA8: begin
          texel_o = {8'hFF, blu, 3'b000, grn, 3'b000, red, 3'b000};
        end
        FMT_BGRA8: begin
          texel_o = {8'hFF, red, 3'b000, grn, 3'b000, blu, 3'b000};
        end
        default: begin
          texel_o = {3'b000, 5'h1F, 2'b00, ext6(blu), 2'b00, ext6(grn), 2'b00, ext6(red)};
        end
      endcase
    end
  end

endmodule

FILE: sv/ctbd_emit.sv
// Texel emitter: block position, palette select, one texel per cycle when not stalled.
`include "compressed_texel_block_decoder_macros.svh"

module ctbd_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_i,
  input  ctbd_pkg::palette_t            pal_i,
  input  logic [31:0]                   word_i,
  input  logic [ctbd_pkg::DIM_W-1:0]    tex_w_i,
  input  logic [ctbd_pkg::BCNT_W-1:0]   bw_i,
  input  logic [ctbd_pkg::BCNT_W-1:0]   bh_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ctbd_pkg::out_item_t           out_item_o,
  output ctbd_pkg::emit_status_t        status_o
);
  import ctbd_pkg::*;

  logic             active_r, active_nxt;
  logic [3:0]       t_r, t_nxt;
  logic [31:0]      word_r, word_nxt;
  palette_t         pal_r, pal_nxt;
  logic [IDX_W-1:0] row_base_r, row_base_nxt;
  logic             last_r, last_nxt;
  logic [BLK_W-1:0] col_r, col_nxt;
  logic [BLK_W-1:0] row_r, row_nxt;

  logic                  fire;
  logic                  blk_end;
  logic                  last_col;
  logic                  last_row;
  logic [18:0]           prod;
  logic [IDX_W-1:0]      base;

  assign fire     = active_r && !out_stall_i;
  assign blk_end  = fire && (t_r == 4'd15);
  assign last_col = ({1'b0, col_r} + 9'd1) >= bw_i;
  assign last_row = ({1'b0, row_r} + 9'd1) >= bh_i;
  assign prod     = 19'(row_r) * 19'(tex_w_i);
  assign base     = IDX_W'({col_r, 2'b00}) + {prod[17:0], 2'b00};

  always_comb begin
    active_nxt   = active_r;
    t_nxt        = t_r;
    word_nxt     = word_r;
    pal_nxt      = pal_r;
    row_base_nxt = row_base_r;
    last_nxt     = last_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (load_i) begin
      active_nxt   = 1'b1;
      t_nxt        = 4'd0;
      word_nxt     = word_i;
      pal_nxt      = pal_i;
      row_base_nxt = base;
      last_nxt     = last_col && last_row;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 8'd1;
      end else begin
        col_nxt = col_r + 8'd1;
      end
    end else if (blk_end) begin
      active_nxt = 1'b0;
    end else if (fire) begin
      t_nxt    = t_r + 4'd1;
      word_nxt = word_r >> 2;
      if (t_r[1:0] == 2'd3) begin
        row_base_nxt = row_base_r + IDX_W'(tex_w_i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      t_r      <= 4'd0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      active_r <= active_nxt;
      t_r      <= t_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    pal_r      <= pal_nxt;
    row_base_r <= row_base_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid_o              = active_r;
  assign out_item_o.texel_value   = pal_r[word_r[1:0]];
  assign out_item_o.texel_index   = row_base_r + IDX_W'(t_r[1:0]);
  assign out_item_o.block_done    = (t_r == 4'd15);
  assign out_item_o.texture_done  = (t_r == 4'd15) && last_r;
  assign status_o.active          = active_r;
  assign status_o.block_end       = blk_end;

  `CTBD_ASSERT_NXT(a_load_starts, load_i, active_r && (t_r == 4'd0), "load did not start block")
  `CTBD_ASSERT_NXT(a_step, fire && (t_r != 4'd15) && !load_i,
                   active_r && (t_r == $past(t_r) + 4'd1), "texel counter skipped")
  `CTBD_ASSERT_NXT(a_row_adv, fire && (t_r[1:0] == 2'd3) && (t_r != 4'd15) && !load_i,
                   row_base_r == $past(row_base_r) + IDX_W'(tex_w_i), "row base not advanced")
  `CTBD_ASSERT_IMP(a_load_ok, load_i, !active_r || blk_end, "load over a live block")

endmodule

FILE: sv/compressed_texel_block_decoder.sv
// Top level of the compressed texel block decoder.
// Takes one 4x4 compressed block per item and delivers its sixteen texels in raster
// order, one per cycle while the output is not stalled, through the single output port
// of the texel emitter. A one-item holding stage takes the next block while the current
// one drains, and four palette lanes build and convert the palette entries in parallel
// as a block moves into the emitter. With the emitter idle, an accepted block is first
// registered in the holding stage and then loaded into the emitter, which presents its
// first texel. Block position restarts at the top left after the last block. Registers
// must be written only while the block is idle; the block itself does not enforce it.
`include "compressed_texel_block_decoder_macros.svh"

module compressed_texel_block_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ctbd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctbd_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_wdata
);
  import ctbd_pkg::*;

  logic             hold_valid_r, hold_valid_nxt;
  in_item_t         hold_item_r, hold_item_nxt;
  logic [1:0]       fmt_r, fmt_nxt;
  logic [DIM_W-1:0] tw_r, tw_nxt;
  logic [DIM_W-1:0] th_r, th_nxt;

  logic             in_fire;
  logic             load;
  emit_status_t     st;
  logic [DIM_W-1:0] w_cl;
  logic [DIM_W-1:0] h_cl;
  logic [2:0]       kind2;
  logic [2:0]       kind3;
  palette_t         pal;

  assign load     = hold_valid_r && (!st.active || st.block_end);
  assign in_stall = hold_valid_r && !load;
  assign in_fire  = in_valid && !in_stall;
  assign w_cl     = clamp_dim(tw_r);
  assign h_cl     = clamp_dim(th_r);

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_item_nxt  = hold_item_r;
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
      hold_item_nxt  = in_item;
    end else if (load) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    fmt_nxt = fmt_r;
    tw_nxt  = tw_r;
    th_nxt  = th_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_FORMAT: fmt_nxt = cfg_wdata[1:0];
        CFG_TEX_WIDTH:  tw_nxt  = cfg_wdata;
        CFG_TEX_HEIGHT: th_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      fmt_r        <= FMT_RGB6A5;
      tw_r         <= DIM_W'(8);
      th_r         <= DIM_W'(8);
    end else begin
      hold_valid_r <= hold_valid_nxt;
      fmt_r        <= fmt_nxt;
      tw_r         <= tw_nxt;
      th_r         <= th_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_item_r <= hold_item_nxt;
  end

  always_comb begin
    case (hold_item_r.pal_mode)
      MODE_TRANSP: begin
        kind2 = KIND_RAW;
        kind3 = KIND_CLEAR;
      end
      MODE_AVG: begin
        kind2 = KIND_AVG;
        kind3 = KIND_CLEAR;
      end
      MODE_BLEND: begin
        kind2 = KIND_MIX53;
        kind3 = KIND_MIX35;
      end
      default: begin
        kind2 = KIND_RAW;
        kind3 = KIND_RAW;
      end
    endcase
  end

  ctbd_lane u_lane0 (
    .c0_i    (hold_item_r.pal_color0),
    .c1_i    (hold_item_r.pal_color1),
    .raw_i   (hold_item_r.pal_color0),
    .kind_i  (KIND_RAW),
    .fmt_i   (fmt_r),
    .texel_o (pal[0])
  );

  ctbd_lane u_lane1 (
    .c0_i    (hold_item_r.pal_color0),
    .c1_i    (hold_item_r.pal_color1),
    .raw_i   (hold_item_r.pal_color1),
    .kind_i  (KIND_RAW),
    .fmt_i   (fmt_r),
    .texel_o (pal[1])
  );

  ctbd_lane u_lane2 (
    .c0_i    (hold_item_r.pal_color0),
    .c1_i    (hold_item_r.pal_color1),
    .raw_i   (hold_item_r.pal_color2),
    .kind_i  (kind2),
    .fmt_i   (fmt_r),
    .texel_o (pal[2])
  );

  ctbd_lane u_lane3 (
    .c0_i    (hold_item_r.pal_color0),
    .c1_i    (hold_item_r.pal_color1),
    .raw_i   (hold_item_r.pal_color3),
    .kind_i  (kind3),
    .fmt_i   (fmt_r),
    .texel_o (pal[3])
  );

  ctbd_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .pal_i       (pal),
    .word_i      (hold_item_r.index_word),
    .tex_w_i     (w_cl),
    .bw_i        (BCNT_W'(w_cl >> 2)),
    .bh_i        (BCNT_W'(h_cl >> 2)),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .status_o    (st)
  );

  `CTBD_ASSERT_NXT(a_hold_fill, in_fire, hold_valid_r, "accepted item not held")
  `CTBD_ASSERT_NXT(a_hold_drain, load && !in_fire, !hold_valid_r, "held item not released")
  `CTBD_ASSERT_IMP(a_stall_busy, in_stall, hold_valid_r && st.active, "stall without work")

endmodule

FILE: sim/tb_top.sv
// Testbench for compressed_texel_block_decoder: predicts each block's texels and checks them.
`timescale 1ns / 1ps

module tb_top;
  import ctbd_pkg::*;

  localparam logic [1:0] FMT_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_OUT_FORMAT;
  logic [10:0] cfg_wdata = '0;

  compressed_texel_block_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  in_item_t    pending_blocks[$];
  out_item_t   expected_texels[$];

  logic [1:0]  fmt_reg = FMT_RGB6A5;
  logic [10:0] width_reg = 11'd8;
  logic [10:0] height_reg = 11'd8;
  int          block_x = 0;
  int          block_y = 0;

  int n_errors = 0;
  int n_blocks = 0;
  int n_textures = 0;
  int n_settings = 0;
  int texels_seen = 0;

  task automatic note_mismatch(string msg);
    n_errors++;
    if (n_errors <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int clamp_texels(logic [10:0] v);
    if (v < 11'd4) return 4;
    if (v > 11'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [14:0] mix555(logic [14:0] a, logic [14:0] c, int wa, int wc, int sh);
    logic [14:0] res;
    int k;
    int ca;
    int cc;
    res = '0;
    for (k = 0; k < 3; k++) begin
      ca = a[5*k +: 5];
      cc = c[5*k +: 5];
      res[5*k +: 5] = 5'((ca * wa + cc * wc) >> sh);
    end
    return res;
  endfunction

  // entry bit 15 is the opaque flag, 14:0 RGB555
  function automatic logic [31:0] to_texel(logic [15:0] e, logic [1:0] fmt);
    logic [4:0] r, g, bl;
    logic [5:0] r6, g6, b6;
    logic [7:0] a8;
    r  = e[4:0];
    g  = e[9:5];
    bl = e[14:10];
    a8 = e[15] ? 8'hFF : 8'h00;
    r6 = (r == 5'd0) ? 6'd0 : {r, 1'b1};
    g6 = (g == 5'd0) ? 6'd0 : {g, 1'b1};
    b6 = (bl == 5'd0) ? 6'd0 : {bl, 1'b1};
    case (fmt)
      FMT_RGBA8: return {a8, bl, 3'b000, g, 3'b000, r, 3'b000};
      FMT_BGRA8: return {a8, r, 3'b000, g, 3'b000, bl, 3'b000};
      default:   return {3'b000, a8[4:0], 2'b00, b6, 2'b00, g6, 2'b00, r6};
    endcase
  endfunction

  function automatic void predict_texels(in_item_t blk);
    logic [15:0] pal [4];
    logic [1:0]  sel;
    out_item_t   o;
    int          w, bw, bh, t, x, y;
    bit          last_col, last_row;
    w  = clamp_texels(width_reg);
    bw = w / 4;
    bh = clamp_texels(height_reg) / 4;
    last_col = (block_x + 1 >= bw);
    last_row = (block_y + 1 >= bh);
    pal[0] = {1'b1, blk.pal_color0};
    pal[1] = {1'b1, blk.pal_color1};
    pal[2] = {1'b1, blk.pal_color2};
    pal[3] = {1'b1, blk.pal_color3};
    case (blk.pal_mode)
      MODE_TRANSP: pal[3] = '0;
      MODE_AVG: begin
        pal[2] = {1'b1, mix555(blk.pal_color0, blk.pal_color1, 1, 1, 1)};
        pal[3] = '0;
      end
      MODE_BLEND: begin
        pal[2] = {1'b1, mix555(blk.pal_color0, blk.pal_color1, 5, 3, 3)};
        pal[3] = {1'b1, mix555(blk.pal_color0, blk.pal_color1, 3, 5, 3)};
      end
      default: ;
    endcase
    for (t = 0; t < 16; t++) begin
      sel = blk.index_word[2*t +: 2];
      x = block_x * 4 + t % 4;
      y = block_y * 4 + t / 4;
      o.texel_value  = to_texel(pal[sel], fmt_reg);
      o.texel_index  = IDX_W'(x + y * w);
      o.block_done   = (t == 15);
      o.texture_done = (t == 15) && last_col && last_row;
      expected_texels.push_back(o);
    end
    if (last_col && last_row) n_textures++;
    if (last_col) begin
      block_x = 0;
      block_y = last_row ? 0 : block_y + 1;
    end else begin
      block_x = block_x + 1;
    end
  endfunction

  // sender: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_texels(in_item);
        n_blocks++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          in_item  <= pending_blocks.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks texels and drives its own stall pattern
  int  stall_style = 0;
  int  style_left = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin : mon
    out_item_t want;
    bit        hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_texels.size() == 0) begin
          note_mismatch($sformatf("texel with nothing expected, index %0d",
                                  out_item.texel_index));
        end else begin
          want = expected_texels.pop_front();
          if (out_item.texel_value !== want.texel_value)
            note_mismatch($sformatf("texel %0d value %h, want %h", texels_seen,
                                    out_item.texel_value, want.texel_value));
          if (out_item.texel_index !== want.texel_index)
            note_mismatch($sformatf("texel %0d index %0d, want %0d", texels_seen,
                                    out_item.texel_index, want.texel_index));
          if (out_item.block_done !== want.block_done)
            note_mismatch($sformatf("texel %0d block_done %b, want %b", texels_seen,
                                    out_item.block_done, want.block_done));
          if (out_item.texture_done !== want.texture_done)
            note_mismatch($sformatf("texel %0d texture_done %b, want %b", texels_seen,
                                    out_item.texture_done, want.texture_done));
        end
        texels_seen++;
      end
      if (!long_hold_done && texels_seen >= 1600) begin
        long_hold_done = 1'b1;
        long_hold_left = 400;
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        hold = 1'b1;
      end else begin
        case (stall_style)
          0: hold = 1'b0;
          1: hold = ($urandom_range(0, 3) == 0);
          2: hold = ($urandom_range(0, 3) != 0);
          default: hold = ~out_stall;
        endcase
      end
      out_stall <= hold;
    end
  end

  function automatic in_item_t mk_block(logic [31:0] idx, logic [1:0] mode, logic [14:0] c0,
                                        logic [14:0] c1, logic [14:0] c2, logic [14:0] c3);
    in_item_t it;
    it.index_word = idx;
    it.pal_mode   = mode;
    it.pal_color0 = c0;
    it.pal_color1 = c1;
    it.pal_color2 = c2;
    it.pal_color3 = c3;
    return it;
  endfunction

  function automatic in_item_t rand_block();
    in_item_t   it;
    logic [1:0] s;
    it.index_word = $urandom();
    it.pal_mode   = 2'($urandom_range(0, 3));
    it.pal_color0 = 15'($urandom());
    it.pal_color1 = 15'($urandom());
    it.pal_color2 = 15'($urandom());
    it.pal_color3 = 15'($urandom());
    s = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: it.index_word = {16{s}};
      1: begin
        it.pal_color0 = '1;
        it.pal_color1 = '0;
      end
      2: begin
        it.pal_color0 = '0;
        it.pal_color1 = '1;
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic logic [10:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 11'($urandom_range(0, 2047));
    if (r == 1) return 11'd1024;
    return 11'(4 << $urandom_range(1, 3));
  endfunction

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || in_valid || expected_texels.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_regs(logic [1:0] fmt, logic [10:0] w, logic [10:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OUT_FORMAT;
    cfg_wdata <= 11'(fmt);
    @(posedge clk);
    cfg_index <= CFG_TEX_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_TEX_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_reg    = fmt;
    width_reg  = w;
    height_reg = h;
    n_settings++;
    @(negedge clk);
  endtask

  initial begin : stim
    int ph, k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset config: RGB6A5, 8x8 texture
    pending_blocks.push_back(mk_block(32'h0, MODE_TRANSP, 15'h0, 15'h0, 15'h0, 15'h0));
    pending_blocks.push_back(mk_block(32'hE4E4E4E4, MODE_TRANSP, '1, '1, '1, '1));
    pending_blocks.push_back(mk_block(32'hE4E4E4E4, MODE_AVG, '1, 15'h0, 15'h1234, '1));
    pending_blocks.push_back(mk_block(32'hE4E4E4E4, MODE_AVG, 15'h7C1F, 15'h03E1, 15'h0, 15'h0));
    pending_blocks.push_back(mk_block(32'hE4E4E4E4, MODE_RAW, 15'h001F, 15'h03E0, 15'h7C00,
                                      15'h7FFF));
    pending_blocks.push_back(mk_block(32'hE4E4E4E4, MODE_BLEND, '1, 15'h0, 15'h0, 15'h0));
    pending_blocks.push_back(mk_block(32'h1B1B1B1B, MODE_BLEND, 15'h0, '1, '1, '1));
    pending_blocks.push_back(mk_block(32'hFFFFFFFF, MODE_RAW, 15'h0, 15'h0, 15'h0, '1));
    pending_blocks.push_back(mk_block(32'hFFFFFFFF, MODE_TRANSP, '1, '1, '1, '1));
    wait_drained();

    write_regs(FMT_RGBA8, 11'd16, 11'd8);
    for (k = 0; k < 4; k++)
      pending_blocks.push_back(mk_block(32'hE4E4E4E4, 2'(k), 15'h5A5A, 15'h2B6D, 15'h7FFF,
                                        15'h0421));
    wait_drained();

    write_regs(FMT_BGRA8, 11'd1024, 11'd1024);
    for (k = 0; k < 4; k++)
      pending_blocks.push_back(mk_block(32'hE4E4E4E4, 2'(k), 15'h001F, 15'h7C00, 15'h03E0,
                                        15'h7FFF));
    wait_drained();

    // width below the minimum leaves the column position past the end
    write_regs(FMT_UNUSED, 11'd0, 11'd2047);
    for (k = 0; k < 3; k++) pending_blocks.push_back(rand_block());
    wait_drained();

    write_regs(FMT_RGB6A5, 11'd5, 11'd3);
    for (k = 0; k < 2; k++) pending_blocks.push_back(rand_block());
    wait_drained();

    for (ph = 0; ph < 10; ph++) begin
      write_regs(2'($urandom_range(0, 3)), pick_dim(), pick_dim());
      for (k = 0; k < 36; k++) pending_blocks.push_back(rand_block());
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("Decoded %0d blocks (%0d texels) over %0d register settings,", n_blocks,
             texels_seen, n_settings);
    $display("all four palette modes and output formats, %0d full textures.", n_textures);
    if (n_errors == 0 && expected_texels.size() == 0) begin
      $display("PASS compressed_texel_block_decoder");
    end else begin
      $display("FAIL compressed_texel_block_decoder");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("Timed out with %0d texels outstanding", expected_texels.size());
    $display("FAIL compressed_texel_block_decoder");
    $finish;
  end

endmodule
